[sv/hsvp_pkg.sv]
// Shared types and constants for the HSV to packed pixel converter.
// No dependencies; every other file imports this package.
package hsvp_pkg;

    localparam int FRACTION_BITS_DEF = 12;

    localparam int HUE_W       = 15;
    localparam int SAT_W       = 13;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int SHIFT_W     = 5;
    localparam int COUNT_W     = 6;
    localparam int FORMAT_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int REM_W       = 12;
    localparam int SECTOR_W    = 3;

    localparam int PIPE_LATENCY = 6;

    localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
    localparam logic [REM_W-1:0] HUE_SECTOR = 12'd3840;

    localparam logic [FORMAT_W-1:0] FMT_RGB  = 2'd0;
    localparam logic [FORMAT_W-1:0] FMT_BGR  = 2'd1;
    localparam logic [FORMAT_W-1:0] FMT_MASK = 2'd2;
    localparam logic [FORMAT_W-1:0] FMT_BLT  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_MASK     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_MASK   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_MASK    = 2'd3;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [SAT_W-1:0] brightness;
    } hsvp_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] pixel_word;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } hsvp_out_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } hsvp_rgb_t;

    typedef struct packed {
        logic [WORD_W-1:0]  quo;
        logic [BYTE_W-1:0]  rmd;
        logic [SHIFT_W-1:0] shift;
    } hsvp_mask_info_t;

    typedef struct packed {
        hsvp_mask_info_t red;
        hsvp_mask_info_t green;
        hsvp_mask_info_t blue;
    } hsvp_mask_set_t;

endpackage

[sv/hsv_to_packed_pixel.sv]
// Top level of the HSV to packed pixel converter: configuration registers and pipeline.
// Depends on hsvp_pkg, hsvp_color, hsvp_mask_decode and hsvp_pack.
//
//   Port group   Direction  Handshake         Word
//   s_*          in         s_valid/s_ready   hsvp_in_t  (hue, saturation, brightness)
//   m_*          out        m_valid/m_ready   hsvp_out_t (pixel_word, red, green, blue)
//   cfg_*        in         cfg_we            index and 32-bit data, write only
//
// One word enters per cycle while s_ready is high and its result leaves after the four
// conversion stages and the two packing stages. Each stage holds its word while the
// next one is full, so a stall at m_ready fills bubbles before it stops s_ready.
// Mask changes pass the mask registers and both decode stages before taking effect.
// Reset clears the valid flags, config and decode registers; the pipeline starts empty.
module hsv_to_packed_pixel import hsvp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  hsvp_in_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output hsvp_out_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]      cfg_wdata
);

    localparam int RUN_W = $clog2(PIPE_LATENCY + 1);

    logic [FORMAT_W-1:0] format_reg;
    logic [WORD_W-1:0]   red_mask_reg, green_mask_reg, blue_mask_reg;

    logic           rgb_valid, rgb_ready;
    hsvp_rgb_t      rgb_data;
    hsvp_mask_set_t mask_set;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg     <= FMT_RGB;
            red_mask_reg   <= '0;
            green_mask_reg <= '0;
            blue_mask_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PIXEL_FORMAT: format_reg     <= cfg_wdata[FORMAT_W-1:0];
                REG_RED_MASK:     red_mask_reg   <= cfg_wdata;
                REG_GREEN_MASK:   green_mask_reg <= cfg_wdata;
                REG_BLUE_MASK:    blue_mask_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    hsvp_color #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_color (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .out_valid(rgb_valid),
        .out_ready(rgb_ready),
        .out_data (rgb_data)
    );

    hsvp_mask_decode u_mask_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .red_mask  (red_mask_reg),
        .green_mask(green_mask_reg),
        .blue_mask (blue_mask_reg),
        .mask_set  (mask_set)
    );

    hsvp_pack u_pack (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (rgb_valid),
        .in_ready    (rgb_ready),
        .in_data     (rgb_data),
        .pixel_format(format_reg),
        .mask_set    (mask_set),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_data    (m_data)
    );

    // Counts consecutive cycles with the output side ready, for the latency check.
    logic [RUN_W-1:0] ready_run_reg;
    logic             s_accept;

    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_run_reg <= '0;
        end else if (!m_ready) begin
            ready_run_reg <= '0;
        end else if (ready_run_reg != RUN_W'(PIPE_LATENCY)) begin
            ready_run_reg <= ready_run_reg + RUN_W'(1);
        end
    end

    a_full_only_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input side blocked while the output side is free");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown straight after reset");

    a_fixed_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(s_accept, PIPE_LATENCY) && $past(aresetn, PIPE_LATENCY)
         && ready_run_reg >= RUN_W'(PIPE_LATENCY - 1)) |-> m_valid)
        else $error("word did not reach the output in the pipeline latency");

endmodule

[sv/hsvp_color.sv]
// Four-stage HSV to 8-bit RGB conversion pipeline with per-stage flow control.
// Depends on hsvp_pkg.
module hsvp_color import hsvp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  hsvp_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output hsvp_rgb_t out_data
);

    localparam int F       = FRACTION_BITS;
    localparam int UNIT_W  = F + 1;
    localparam int CMP_W   = (UNIT_W > SAT_W) ? UNIT_W : SAT_W;
    localparam int INNER_W = F + REM_W;
    localparam int VZ_W    = 2 * F + 1;
    localparam int PROD_W  = 2 * F + REM_W;
    localparam int XMUL_W  = PROD_W + 5;

    logic s1_ready, s2_ready, s3_ready, s4_ready;

    logic                s1_valid_reg;
    logic [UNIT_W-1:0]   s1_sat_reg, s1_bri_reg, s1_nsat_reg;
    logic [REM_W-1:0]    s1_t_reg;
    logic [SECTOR_W-1:0] s1_sector_reg;

    logic                s2_valid_reg;
    logic [UNIT_W-1:0]   s2_bri_reg;
    logic [INNER_W-1:0]  s2_inner_reg;
    logic [VZ_W-1:0]     s2_vz_reg;
    logic [BYTE_W-1:0]   s2_cbyte_reg;
    logic [SECTOR_W-1:0] s2_sector_reg;

    logic                s3_valid_reg;
    logic [PROD_W-1:0]   s3_xm_reg;
    logic [BYTE_W-1:0]   s3_zbyte_reg, s3_cbyte_reg;
    logic [SECTOR_W-1:0] s3_sector_reg;

    logic                s4_valid_reg;
    hsvp_rgb_t           s4_rgb_reg;

    logic [CMP_W-1:0]    sat_ext, bri_ext, unit_one;
    logic [HUE_W-1:0]    hue_wrap, hue_base;
    logic [REM_W-1:0]    hue_rem;
    logic [UNIT_W-1:0]   s1_sat_next, s1_bri_next, s1_nsat_next;
    logic [REM_W-1:0]    s1_t_next;
    logic [SECTOR_W-1:0] s1_sector_next;

    logic [INNER_W:0]    inner_sum;
    logic [UNIT_W+7:0]   c_mul;
    logic [INNER_W-1:0]  s2_inner_next;
    logic [VZ_W-1:0]     s2_vz_next;
    logic [BYTE_W-1:0]   s2_cbyte_next;

    logic [VZ_W+7:0]     z_mul;
    logic [PROD_W-1:0]   s3_xm_next;
    logic [BYTE_W-1:0]   s3_zbyte_next;

    logic [XMUL_W-1:0]   x_mul;
    logic [BYTE_W-1:0]   xbyte;
    hsvp_rgb_t           s4_rgb_next;

    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s4_valid_reg;
    assign out_data  = s4_rgb_reg;

    always_comb begin
        unit_one    = CMP_W'(1) << F;
        sat_ext     = CMP_W'(in_data.saturation);
        bri_ext     = CMP_W'(in_data.brightness);
        s1_sat_next = (sat_ext > unit_one) ? UNIT_W'(unit_one) : UNIT_W'(sat_ext);
        s1_bri_next = (bri_ext > unit_one) ? UNIT_W'(unit_one) : UNIT_W'(bri_ext);
        s1_nsat_next = UNIT_W'(unit_one) - s1_sat_next;

        hue_wrap = (in_data.hue >= HUE_FULL) ? in_data.hue - HUE_FULL : in_data.hue;
        s1_sector_next = '0;
        hue_base       = '0;
        for (int k = 1; k < 6; k++) begin
            if (hue_wrap >= HUE_W'(k * int'(HUE_SECTOR))) begin
                s1_sector_next = SECTOR_W'(k);
                hue_base       = HUE_W'(k * int'(HUE_SECTOR));
            end
        end
        hue_rem   = REM_W'(hue_wrap - hue_base);
        s1_t_next = s1_sector_next[0] ? HUE_SECTOR - hue_rem : hue_rem;
    end

    always_comb begin
        inner_sum = (INNER_W + 1)'(s1_sat_reg) * (INNER_W + 1)'(s1_t_reg)
                  + (INNER_W + 1)'(s1_nsat_reg) * (INNER_W + 1)'(HUE_SECTOR);
        s2_inner_next = INNER_W'(inner_sum);
        s2_vz_next    = VZ_W'(s1_bri_reg) * VZ_W'(s1_nsat_reg);
        c_mul         = (UNIT_W + 8)'(s1_bri_reg) * (UNIT_W + 8)'(255);
        s2_cbyte_next = c_mul[F+7:F];
    end

    always_comb begin
        s3_xm_next    = PROD_W'(s2_bri_reg) * PROD_W'(s2_inner_reg);
        z_mul         = (VZ_W + 8)'(s2_vz_reg) * (VZ_W + 8)'(255);
        s3_zbyte_next = z_mul[2*F+7:2*F];
    end

    // 255/3840 reduces to 17/256, so no division by the sector length is needed.
    always_comb begin
        x_mul = XMUL_W'(s3_xm_reg) * XMUL_W'(17);
        xbyte = x_mul[2*F+15:2*F+8];
        case (s3_sector_reg)
            3'd0: s4_rgb_next = '{red: s3_cbyte_reg, green: xbyte, blue: s3_zbyte_reg};
            3'd1: s4_rgb_next = '{red: xbyte, green: s3_cbyte_reg, blue: s3_zbyte_reg};
            3'd2: s4_rgb_next = '{red: s3_zbyte_reg, green: s3_cbyte_reg, blue: xbyte};
            3'd3: s4_rgb_next = '{red: s3_zbyte_reg, green: xbyte, blue: s3_cbyte_reg};
            3'd4: s4_rgb_next = '{red: xbyte, green: s3_zbyte_reg, blue: s3_cbyte_reg};
            default: s4_rgb_next = '{red: s3_cbyte_reg, green: s3_zbyte_reg, blue: xbyte};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_sat_reg    <= s1_sat_next;
            s1_bri_reg    <= s1_bri_next;
            s1_nsat_reg   <= s1_nsat_next;
            s1_t_reg      <= s1_t_next;
            s1_sector_reg <= s1_sector_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_bri_reg    <= s1_bri_reg;
            s2_inner_reg  <= s2_inner_next;
            s2_vz_reg     <= s2_vz_next;
            s2_cbyte_reg  <= s2_cbyte_next;
            s2_sector_reg <= s1_sector_reg;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_xm_reg     <= s3_xm_next;
            s3_zbyte_reg  <= s3_zbyte_next;
            s3_cbyte_reg  <= s2_cbyte_reg;
            s3_sector_reg <= s2_sector_reg;
        end
        if (s4_ready && s3_valid_reg) begin
            s4_rgb_reg <= s4_rgb_next;
        end
    end

endmodule

[sv/hsvp_mask_decode.sv]
// Decodes the three component masks into scale factors and shift amounts.
// Two register stages; depends on hsvp_pkg.
module hsvp_mask_decode import hsvp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [WORD_W-1:0] red_mask,
    input  logic [WORD_W-1:0] green_mask,
    input  logic [WORD_W-1:0] blue_mask,
    output hsvp_mask_set_t    mask_set
);

    typedef logic [WORD_W:0][WORD_W-1:0] quo_table_t;
    typedef logic [WORD_W:0][BYTE_W-1:0] rmd_table_t;

    // The all-ones value of each possible width, split as 255 * quo + rmd.
    function automatic quo_table_t build_quo_table();
        quo_table_t       tbl;
        logic [WORD_W:0]  full;
        for (int w = 0; w <= WORD_W; w++) begin
            full   = ((WORD_W + 1)'(1) << w) - (WORD_W + 1)'(1);
            tbl[w] = WORD_W'(full / (WORD_W + 1)'(255));
        end
        return tbl;
    endfunction

    function automatic rmd_table_t build_rmd_table();
        rmd_table_t       tbl;
        logic [WORD_W:0]  full;
        for (int w = 0; w <= WORD_W; w++) begin
            full   = ((WORD_W + 1)'(1) << w) - (WORD_W + 1)'(1);
            tbl[w] = BYTE_W'(full % (WORD_W + 1)'(255));
        end
        return tbl;
    endfunction

    localparam quo_table_t QUO_TABLE = build_quo_table();
    localparam rmd_table_t RMD_TABLE = build_rmd_table();

    function automatic logic [COUNT_W-1:0] count_ones(input logic [WORD_W-1:0] m);
        logic [3:0]         part [4];
        logic [COUNT_W-1:0] total;
        for (int b = 0; b < 4; b++) begin
            part[b] = '0;
            for (int i = 0; i < 8; i++) begin
                part[b] = part[b] + 4'(m[8*b+i]);
            end
        end
        total = COUNT_W'(part[0]) + COUNT_W'(part[1]) + COUNT_W'(part[2])
              + COUNT_W'(part[3]);
        return total;
    endfunction

    function automatic logic [SHIFT_W-1:0] lowest_one(input logic [WORD_W-1:0] m);
        logic [1:0] byte_sel;
        logic [7:0] byte_val;
        logic [2:0] bit_sel;
        byte_sel = 2'd3;
        for (int b = 3; b >= 0; b--) begin
            if (m[8*b +: 8] != 8'd0) byte_sel = 2'(b);
        end
        byte_val = m[8*byte_sel +: 8];
        bit_sel  = 3'd7;
        for (int i = 7; i >= 0; i--) begin
            if (byte_val[i]) bit_sel = 3'(i);
        end
        return {byte_sel, bit_sel};
    endfunction

    logic [WORD_W-1:0]  masks [3];
    logic [COUNT_W-1:0] count_reg [3];
    logic [SHIFT_W-1:0] low_reg [3];
    hsvp_mask_info_t    info_reg [3];

    assign masks[0] = red_mask;
    assign masks[1] = green_mask;
    assign masks[2] = blue_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                count_reg[c] <= '0;
                low_reg[c]   <= '0;
                info_reg[c]  <= '0;
            end
        end else begin
            for (int c = 0; c < 3; c++) begin
                count_reg[c]      <= count_ones(masks[c]);
                low_reg[c]        <= lowest_one(masks[c]);
                info_reg[c].quo   <= QUO_TABLE[count_reg[c]];
                info_reg[c].rmd   <= RMD_TABLE[count_reg[c]];
                info_reg[c].shift <= low_reg[c];
            end
        end
    end

    assign mask_set.red   = info_reg[0];
    assign mask_set.green = info_reg[1];
    assign mask_set.blue  = info_reg[2];

endmodule

[sv/hsvp_pack.sv]
// Two-stage packer: scales components into masks and assembles the pixel word.
// Depends on hsvp_pkg.
module hsvp_pack import hsvp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  hsvp_rgb_t           in_data,
    input  logic [FORMAT_W-1:0] pixel_format,
    input  hsvp_mask_set_t      mask_set,
    output logic                out_valid,
    input  logic                out_ready,
    output hsvp_out_t           out_data
);

    logic s5_ready, s6_ready;

    hsvp_mask_info_t    info [3];
    logic [BYTE_W-1:0]  comp [3];

    logic               s5_valid_reg;
    hsvp_rgb_t          s5_rgb_reg;
    logic [WORD_W-1:0]  s5_hi_reg [3];
    logic [15:0]        s5_lo_reg [3];
    logic [WORD_W-1:0]  s5_hi_next [3];
    logic [15:0]        s5_lo_next [3];

    logic               s6_valid_reg;
    hsvp_out_t          s6_out_reg;
    hsvp_out_t          s6_out_next;

    logic [WORD_W+7:0]  hi_mul [3];
    logic [16:0]        lo_adj [3];
    logic [WORD_W:0]    scaled_sum [3];
    logic [WORD_W-1:0]  placed [3];

    assign s6_ready  = !s6_valid_reg || out_ready;
    assign s5_ready  = !s5_valid_reg || s6_ready;
    assign in_ready  = s5_ready;
    assign out_valid = s6_valid_reg;
    assign out_data  = s6_out_reg;

    assign info[0] = mask_set.red;
    assign info[1] = mask_set.green;
    assign info[2] = mask_set.blue;
    assign comp[0] = in_data.red;
    assign comp[1] = in_data.green;
    assign comp[2] = in_data.blue;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            hi_mul[c]     = (WORD_W + 8)'(comp[c]) * (WORD_W + 8)'(info[c].quo);
            s5_hi_next[c] = WORD_W'(hi_mul[c]);
            s5_lo_next[c] = 16'(comp[c]) * 16'(info[c].rmd);
        end
    end

    // The low part stays below 2^16, where (x + 1 + x/256) / 256 equals x / 255.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            lo_adj[c]     = 17'(s5_lo_reg[c]) + 17'(1) + 17'(s5_lo_reg[c][15:8]);
            scaled_sum[c] = (WORD_W + 1)'(s5_hi_reg[c]) + (WORD_W + 1)'(lo_adj[c][15:8]);
            placed[c]     = WORD_W'(scaled_sum[c]) << info[c].shift;
        end
        s6_out_next.red   = s5_rgb_reg.red;
        s6_out_next.green = s5_rgb_reg.green;
        s6_out_next.blue  = s5_rgb_reg.blue;
        case (pixel_format)
            FMT_RGB: s6_out_next.pixel_word = {8'd0, s5_rgb_reg.blue, s5_rgb_reg.green,
                                               s5_rgb_reg.red};
            FMT_BGR: s6_out_next.pixel_word = {8'd0, s5_rgb_reg.red, s5_rgb_reg.green,
                                               s5_rgb_reg.blue};
            FMT_MASK: s6_out_next.pixel_word = placed[0] | placed[1] | placed[2];
            default: s6_out_next.pixel_word = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else begin
            if (s5_ready) s5_valid_reg <= in_valid;
            if (s6_ready) s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_ready && in_valid) begin
            s5_rgb_reg <= in_data;
            for (int c = 0; c < 3; c++) begin
                s5_hi_reg[c] <= s5_hi_next[c];
                s5_lo_reg[c] <= s5_lo_next[c];
            end
        end
        if (s6_ready && s5_valid_reg) begin
            s6_out_reg <= s6_out_next;
        end
    end

endmodule

[dv/hsvp_checker.sv]
// Watches both channels and the register port of the HSV to packed pixel converter.
// It predicts every result word from its own copy of the registers and compares it.
// Depends on hsvp_pkg for the word types, formats and register indexes.
module hsvp_checker import hsvp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  hsvp_in_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  hsvp_out_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]      cfg_wdata,
    output int                     fail_count,
    output int                     pending
);

    logic [FORMAT_W-1:0] fmt_copy;
    logic [WORD_W-1:0]   red_mask_copy;
    logic [WORD_W-1:0]   green_mask_copy;
    logic [WORD_W-1:0]   blue_mask_copy;
    hsvp_out_t           expected_pixels[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [BYTE_W-1:0] scale_byte(input longint unsigned num,
                                                     input longint unsigned den);
        longint unsigned q;
        q = (num * 64'd255) / den;
        return (q > 64'd255) ? 8'hFF : q[BYTE_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] fit_mask(input logic [WORD_W-1:0] mask,
                                                   input logic [BYTE_W-1:0] comp);
        int              lsb;
        longint unsigned top_val;
        longint unsigned scaled;
        if (mask == '0) begin
            return '0;
        end
        lsb = 0;
        while (lsb < 31 && !mask[lsb]) begin
            lsb++;
        end
        top_val = (64'd1 << $countones(mask)) - 64'd1;
        scaled  = (64'(comp) * top_val) / 64'd255;
        return WORD_W'(scaled << lsb);
    endfunction

    function automatic hsvp_out_t convert_hsv(input hsvp_in_t w);
        longint unsigned one_q;
        longint unsigned sat;
        longint unsigned val;
        longint unsigned den;
        longint unsigned cn;
        longint unsigned xn;
        longint unsigned mn;
        longint unsigned rn;
        longint unsigned gn;
        longint unsigned bn;
        longint unsigned span;
        int unsigned     h;
        int unsigned     sector;
        int unsigned     rem_h;
        hsvp_out_t       res;

        one_q = 64'd1 << FRACTION_BITS_DEF;
        sat   = 64'(w.saturation);
        val   = 64'(w.brightness);
        if (sat > one_q) begin
            sat = one_q;
        end
        if (val > one_q) begin
            val = one_q;
        end
        h = 32'(w.hue);
        if (h >= 32'(HUE_FULL)) begin
            h = h - 32'(HUE_FULL);
        end
        sector = h / 32'(HUE_SECTOR);
        rem_h  = h % 32'(HUE_SECTOR);
        span   = (sector % 2 == 1) ? 64'(32'(HUE_SECTOR) - rem_h) : 64'(rem_h);

        den = 64'(HUE_SECTOR) << (2 * FRACTION_BITS_DEF);
        cn  = val * sat * 64'(HUE_SECTOR);
        xn  = val * sat * span;
        mn  = ((val << FRACTION_BITS_DEF) * 64'(HUE_SECTOR)) - cn;

        case (sector)
            0: begin rn = cn; gn = xn; bn = 0;  end
            1: begin rn = xn; gn = cn; bn = 0;  end
            2: begin rn = 0;  gn = cn; bn = xn; end
            3: begin rn = 0;  gn = xn; bn = cn; end
            4: begin rn = xn; gn = 0;  bn = cn; end
            default: begin rn = cn; gn = 0; bn = xn; end
        endcase

        res.red   = scale_byte(rn + mn, den);
        res.green = scale_byte(gn + mn, den);
        res.blue  = scale_byte(bn + mn, den);

        case (fmt_copy)
            FMT_RGB:  res.pixel_word = {8'h00, res.blue, res.green, res.red};
            FMT_BGR:  res.pixel_word = {8'h00, res.red, res.green, res.blue};
            FMT_MASK: res.pixel_word = fit_mask(red_mask_copy, res.red)
                                     | fit_mask(green_mask_copy, res.green)
                                     | fit_mask(blue_mask_copy, res.blue);
            default:  res.pixel_word = '0;
        endcase
        return res;
    endfunction

    task automatic note_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
        if (want !== got) begin
            if (fail_count < 10) begin
                $display("checker: %s mismatch, expected %h, got %h", field, want, got);
            end
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        hsvp_out_t want;
        if (!aresetn) begin
            fmt_copy        = FMT_RGB;
            red_mask_copy   = '0;
            green_mask_copy = '0;
            blue_mask_copy  = '0;
            expected_pixels.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_PIXEL_FORMAT: fmt_copy        = cfg_wdata[FORMAT_W-1:0];
                    REG_RED_MASK:     red_mask_copy   = cfg_wdata;
                    REG_GREEN_MASK:   green_mask_copy = cfg_wdata;
                    REG_BLUE_MASK:    blue_mask_copy  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("checker: unexpected result word %h", m_data);
                    end
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    note_field("pixel_word", want.pixel_word, m_data.pixel_word);
                    note_field("red", WORD_W'(want.red), WORD_W'(m_data.red));
                    note_field("green", WORD_W'(want.green), WORD_W'(m_data.green));
                    note_field("blue", WORD_W'(want.blue), WORD_W'(m_data.blue));
                end
            end
            if (s_valid && s_ready) begin
                expected_pixels.push_back(convert_hsv(s_data));
            end
        end
        pending = expected_pixels.size();
    end

endmodule

[dv/tb.sv]
// Top of the converter testbench: clock, reset, register set-up and word stimulus.
// Depends on hsvp_pkg, hsv_to_packed_pixel and hsvp_checker, which does the checking.
module tb import hsvp_pkg::*;;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    hsvp_in_t               s_data;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    hsvp_out_t              m_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_addr;
    logic [WORD_W-1:0]      cfg_wdata;
    int                     fail_count;
    int                     pending;
    int                     send_gap_pct;
    int                     ready_gap_pct;
    bit                     no_idle;
    int                     stall_left;
    int                     idle_cycles;

    always #6 aclk = ~aclk;

    hsv_to_packed_pixel i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    hsvp_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver stalls in bursts, except in the closing stretch.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < ready_gap_pct) begin
            stall_left <= $urandom_range(1, 17) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic hsvp_in_t pick_hsv();
        hsvp_in_t w;
        if ($urandom_range(0, 9) == 0) begin
            // Whole field range, so that out-of-range hue and fractions above one occur.
            w.hue        = HUE_W'($urandom_range(0, 32767));
            w.saturation = SAT_W'($urandom_range(0, 8191));
            w.brightness = SAT_W'($urandom_range(0, 8191));
        end else begin
            w.hue        = HUE_W'($urandom_range(0, 23039));
            w.saturation = ($urandom_range(0, 7) == 0) ? 13'd4096
                                                       : SAT_W'($urandom_range(0, 4096));
            w.brightness = ($urandom_range(0, 7) == 0) ? 13'd4096
                                                       : SAT_W'($urandom_range(0, 4096));
        end
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] pick_mask();
        int              span;
        int              lsb;
        longint unsigned run;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                span = $urandom_range(1, 32);
                lsb  = $urandom_range(0, 32 - span);
                run  = ((64'd1 << span) - 64'd1) << lsb;
                return run[WORD_W-1:0];
            end
            2: return '0;
            default: return 32'd1 << $urandom_range(0, 31);
        endcase
    endfunction

    task automatic push_word(input hsvp_in_t w);
        if (!no_idle && $urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drive_hsv(input int h, input int sat, input int val);
        hsvp_in_t w;
        w.hue        = HUE_W'(h);
        w.saturation = SAT_W'(sat);
        w.brightness = SAT_W'(val);
        push_word(w);
    endtask

    task automatic stream_words(input int count, input int send_pct, input int ready_pct);
        send_gap_pct  = send_pct;
        ready_gap_pct = ready_pct;
        repeat (count) push_word(pick_hsv());
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [FORMAT_W-1:0] fmt, input logic [WORD_W-1:0] rm,
                               input logic [WORD_W-1:0] gm, input logic [WORD_W-1:0] bm);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [WORD_W-1:0]      vals [4];
        idx  = '{REG_PIXEL_FORMAT, REG_RED_MASK, REG_GREEN_MASK, REG_BLUE_MASK};
        vals = '{WORD_W'(fmt), rm, gm, bm};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        // Mask changes pass the mask register and both decode stages to the packing stage.
        repeat (3) @(negedge aclk);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        send_gap_pct  = 30;
        ready_gap_pct = 30;
        no_idle       = 1'b0;
        stall_left    = 0;
        idle_cycles   = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Registers at their reset values: RGB order, all masks zero.
        drive_hsv(0, 4096, 4096);
        drive_hsv(3839, 4096, 4096);
        drive_hsv(3840, 4096, 4096);
        drive_hsv(7680, 4096, 4096);
        drive_hsv(11520, 4096, 4096);
        drive_hsv(15360, 4096, 4096);
        drive_hsv(19200, 4096, 4096);
        drive_hsv(23039, 4096, 4096);
        drive_hsv(23040, 4096, 4096);
        drive_hsv(32767, 8191, 8191);
        drive_hsv(16384, 4097, 4097);
        drive_hsv(1920, 4096, 4096);
        drive_hsv(5760, 2048, 4096);
        drive_hsv(9600, 4096, 2048);
        drive_hsv(13440, 0, 4096);
        drive_hsv(17280, 4096, 0);
        drive_hsv(21120, 0, 0);
        drive_hsv(100, 8191, 4096);
        drive_hsv(100, 4096, 8191);
        drive_hsv(0, 1, 1);
        drive_hsv(19999, 4095, 4095);
        drive_hsv(27000, 5000, 6000);
        stream_words(150, 30, 30);
        drain();

        load_config(FMT_BGR, '0, '0, '0);
        stream_words(180, 20, 40);
        drain();

        load_config(FMT_MASK, 32'h0000F800, 32'h000007E0, 32'h0000001F);
        stream_words(180, 0, 0);
        drain();

        load_config(FMT_MASK, 32'hFFFFFFFF, 32'h00000000, 32'hA5000F00);
        stream_words(180, 40, 20);
        drain();

        load_config(FMT_MASK, 32'h80000000, 32'h00000001, 32'h7FFFFFFE);
        stream_words(150, 25, 25);
        drain();

        load_config(FMT_BLT, pick_mask(), pick_mask(), pick_mask());
        stream_words(150, 15, 35);
        drain();

        repeat (3) begin
            load_config(FMT_MASK, pick_mask(), pick_mask(), pick_mask());
            stream_words(120, $urandom_range(0, 40), $urandom_range(0, 40));
            drain();
        end

        load_config(FMT_RGB, 32'hFF0000FF, 32'h00FFFF00, 32'hFFFFFFFF);
        no_idle = 1'b1;
        stream_words(150, 0, 0);
        drain();

        repeat (PIPE_LATENCY + 4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
sv/hsvp_pkg.sv
sv/hsvp_color.sv
sv/hsvp_mask_decode.sv
sv/hsvp_pack.sv
sv/hsv_to_packed_pixel.sv
dv/hsvp_checker.sv
dv/tb.sv
